/* sv/ddpbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpbd_pkg
// Shared constants, command codes and the front-to-back command type of the
// 4-bit differential PCM block decoder.
// ----------------------------------------------------------------------------
package ddpbd_pkg;

  localparam int BLOCK_SAMPLES = 32;
  localparam int MAP_COUNT     = 64;
  localparam int MAP_ENTRIES   = 16;
  localparam int BLOCK_BYTES   = 2 + (BLOCK_SAMPLES + 1) / 2;
  localparam int TABLE_DEPTH   = MAP_COUNT * MAP_ENTRIES;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int MAP_W  = $clog2(MAP_COUNT);
  localparam int NIB_W  = $clog2(MAP_ENTRIES);
  localparam int POS_W  = $clog2(BLOCK_BYTES);
  localparam int CNT_W  = POS_W + 1;
  localparam int SMP_W  = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // command kinds
  localparam logic [1:0] CMD_TWR   = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DEC   = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [SMP_W-1:0]  data;
    logic              order;
    logic              last;
  } cmd_t;

endpackage

/* sv/ddpbd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ddpbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/ddpbd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpbd_queue
// Short command queue between the byte front end and the sample back end.
// ----------------------------------------------------------------------------
module ddpbd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ddpbd_pkg::cmd_t   push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ddpbd_pkg::cmd_t   head_cmd
);

  ddpbd_pkg::cmd_t                  ent_r [ddpbd_pkg::QUEUE_DEPTH];
  logic [ddpbd_pkg::QPTR_W-1:0]     wptr_r;
  logic [ddpbd_pkg::QPTR_W-1:0]     rptr_r;
  logic [ddpbd_pkg::QPTR_W:0]       cnt_r;
  logic [ddpbd_pkg::QPTR_W:0]       cnt_nxt;

  assign full       = (cnt_r == (ddpbd_pkg::QPTR_W + 1)'(ddpbd_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = ent_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue pop while empty");

endmodule

/* sv/ddpbd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpbd_front
// Accepts items, tracks the position in the block and turns table items and
// coded bytes into table-write, start or decode commands for the back end.
// ----------------------------------------------------------------------------
module ddpbd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [7:0]          in_code_byte,
  input  logic [9:0]          in_table_index,
  input  logic signed [15:0]  in_table_value,
  input  logic                q_full,
  output logic                push,
  output ddpbd_pkg::cmd_t     push_cmd
);

  logic [ddpbd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                  lowb_r, lowb_nxt;
  logic [ddpbd_pkg::MAP_W-1:0] map_r, map_nxt;
  logic                        order_r, order_nxt;
  logic                        pend_r, pend_nxt;
  ddpbd_pkg::cmd_t             pend_cmd_r, pend_cmd_nxt;
  logic                        accept;
  logic [ddpbd_pkg::POS_W:0]   pos_inc;
  logic [ddpbd_pkg::CNT_W-1:0] cnt;
  logic [ddpbd_pkg::CNT_W-1:0] bs_c;

  assign in_stall = pend_r || q_full;
  assign accept   = in_valid && !in_stall;
  assign pos_inc  = {1'b0, pos_r} + 1'b1;
  // samples already emitted before this byte
  assign cnt      = ddpbd_pkg::CNT_W'({pos_r, 1'b0}) - ddpbd_pkg::CNT_W'(4);
  assign bs_c     = ddpbd_pkg::CNT_W'(ddpbd_pkg::BLOCK_SAMPLES);

  always_comb begin
    pos_nxt      = pos_r;
    lowb_nxt     = lowb_r;
    map_nxt      = map_r;
    order_nxt    = order_r;
    pend_nxt     = pend_r;
    pend_cmd_nxt = pend_cmd_r;
    push         = 1'b0;
    push_cmd     = '0;
    if (pend_r && !q_full) begin
      push     = 1'b1;
      push_cmd = pend_cmd_r;
      pend_nxt = 1'b0;
    end
    if (accept) begin
      if (in_req_type) begin
        push          = 1'b1;
        push_cmd.kind = ddpbd_pkg::CMD_TWR;
        push_cmd.addr = in_table_index;
        push_cmd.data = in_table_value;
      end else if (pos_r == '0) begin
        lowb_nxt = in_code_byte;
        pos_nxt  = ddpbd_pkg::POS_W'(1);
      end else if (pos_r == ddpbd_pkg::POS_W'(1)) begin
        push          = 1'b1;
        push_cmd.kind = ddpbd_pkg::CMD_START;
        push_cmd.data = {in_code_byte, lowb_r};
        pos_nxt       = ddpbd_pkg::POS_W'(2);
      end else if (pos_r == ddpbd_pkg::POS_W'(2)) begin
        map_nxt        = {lowb_r[2:0], in_code_byte[7:5]};
        order_nxt      = in_code_byte[4];
        push           = 1'b1;
        push_cmd.kind  = ddpbd_pkg::CMD_DEC;
        push_cmd.addr  = {map_nxt, in_code_byte[3:0]};
        push_cmd.order = order_nxt;
        push_cmd.last  = 1'(ddpbd_pkg::BLOCK_SAMPLES <= 2);
        pos_nxt        = ddpbd_pkg::POS_W'(3);
      end else begin
        push           = 1'b1;
        push_cmd.kind  = ddpbd_pkg::CMD_DEC;
        push_cmd.addr  = {map_r, in_code_byte[7:4]};
        push_cmd.order = order_r;
        push_cmd.last  = ((cnt + 1'b1) >= bs_c);
        if ((cnt + 1'b1) < bs_c) begin
          pend_nxt           = 1'b1;
          pend_cmd_nxt.kind  = ddpbd_pkg::CMD_DEC;
          pend_cmd_nxt.addr  = {map_r, in_code_byte[3:0]};
          pend_cmd_nxt.data  = '0;
          pend_cmd_nxt.order = order_r;
          pend_cmd_nxt.last  = ((cnt + 2'd2) >= bs_c);
        end
        if (pos_inc >= (ddpbd_pkg::POS_W + 1)'(ddpbd_pkg::BLOCK_BYTES)) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_inc[ddpbd_pkg::POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_cmd_r <= pend_cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      lowb_r  <= '0;
      map_r   <= '0;
      order_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      lowb_r  <= lowb_nxt;
      map_r   <= map_nxt;
      order_r <= order_nxt;
      pend_r  <= pend_nxt;
    end
  end

  a_pend_only_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(pend_r) |-> $past(accept) && !$past(in_req_type))
    else $error("second nibble pending without a coded byte");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_r} < (ddpbd_pkg::POS_W + 1)'(ddpbd_pkg::BLOCK_BYTES))
    else $error("block position out of range");

endmodule

/* sv/ddpbd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpbd_back
// Executes queued commands: table writes, delta lookup in the table RAM,
// prediction, saturation and the registered sample output.
// ----------------------------------------------------------------------------
module ddpbd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  ddpbd_pkg::cmd_t     head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_sample,
  output logic                out_block_last
);

  logic                      s1_v_r;
  ddpbd_pkg::cmd_t           s1_cmd_r;
  logic                      s1_free, s1_move;
  logic                      out_v_r;
  logic signed [15:0]        out_sample_r;
  logic                      out_last_r;
  logic signed [15:0]        last_r, older_r;
  logic [15:0]               rdata;
  logic                      is_twr, is_dec;
  logic signed [18:0]        pred, sum;
  logic signed [15:0]        delta, res;

  assign is_twr  = (head_cmd.kind == ddpbd_pkg::CMD_TWR);
  assign is_dec  = (head_cmd.kind == ddpbd_pkg::CMD_DEC);
  assign s1_move = s1_v_r && (!out_v_r || !out_stall);
  assign s1_free = !s1_v_r || s1_move;
  assign pop     = head_valid && (is_twr || s1_free);

  ddpbd_ram #(
    .WIDTH(16),
    .DEPTH(ddpbd_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (head_valid && is_twr),
    .waddr (head_cmd.addr),
    .wdata (head_cmd.data),
    .re    (pop && is_dec),
    .raddr (head_cmd.addr),
    .rdata (rdata)
  );

  always_comb begin
    delta = $signed(rdata);
    if (s1_cmd_r.order) begin
      pred = (19'(last_r) <<< 1) - 19'(older_r);
    end else begin
      pred = 19'(last_r);
    end
    sum = pred + 19'(delta);
    if (sum > 19'sd32767) begin
      res = 16'sh7fff;
    end else if (sum < -19'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_cmd_r <= head_cmd;
    end
    if (s1_move) begin
      out_last_r <= s1_cmd_r.last;
      if (s1_cmd_r.kind == ddpbd_pkg::CMD_START) begin
        out_sample_r <= $signed(s1_cmd_r.data);
      end else begin
        out_sample_r <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      last_r  <= '0;
      older_r <= '0;
    end else begin
      if (s1_free) begin
        s1_v_r <= pop && !is_twr;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
      if (s1_move) begin
        if (s1_cmd_r.kind == ddpbd_pkg::CMD_START) begin
          last_r  <= $signed(s1_cmd_r.data);
          older_r <= $signed(s1_cmd_r.data);
        end else begin
          last_r  <= res;
          older_r <= last_r;
        end
      end
    end
  end

  assign out_valid      = out_v_r;
  assign out_sample     = out_sample_r;
  assign out_block_last = out_last_r;

  a_move_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_v_r)
    else $error("sample lost between lookup and output");

  a_twr_never_staged: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> s1_cmd_r.kind != ddpbd_pkg::CMD_TWR)
    else $error("table write entered the sample stage");

endmodule

/* sv/ddpcm_4bit_block_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddpcm_4bit_block_decoder
// 4-bit differential PCM block decoder with 64 selectable delta maps.
// ----------------------------------------------------------------------------
// Each coded byte after the block header yields two samples, and the back end
// produces one sample per cycle, unless the output stalls, through its single
// table lookup and predictor adder, so each sample byte holds the input until
// its second nibble is queued; table writes and the three header bytes are
// taken one per cycle while the queue is not full. Samples pass the command
// queue, table RAM read and output register. Load the delta table with
// table-write items before decoding; entries never written read as undefined.
// A 4-entry command queue keeps the input flowing while the output stalls.
module ddpcm_4bit_block_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [7:0]          in_code_byte,
  input  logic [9:0]          in_table_index,
  input  logic signed [15:0]  in_table_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_sample,
  output logic                out_block_last
);

  logic            push, q_full, pop, head_valid;
  ddpbd_pkg::cmd_t push_cmd, head_cmd;

  ddpbd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_code_byte   (in_code_byte),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  ddpbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ddpbd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .out_block_last (out_block_last)
  );

endmodule
